// ===== rtl/core/smpq_pkg.sv =====
// Shared types and constants of the sorted max-priority queue.
package smpq_pkg;

  // Store size and value range
  localparam int unsigned CapacityDef = 128;
  localparam int unsigned ValueW      = 10;
  localparam int unsigned OpW         = 2;
  localparam int unsigned StatusW     = 2;

  localparam logic [ValueW-1:0] ValueMin = 10'd1;
  localparam logic [ValueW-1:0] ValueMax = 10'd1000;

  // Request opcodes; the fourth code is reserved and answers as invalid
  typedef enum logic [OpW-1:0] {
    OpInsert = 2'd0,
    OpDelete = 2'd1,
    OpClear  = 2'd2
  } opcode_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    StOk      = 2'd0,
    StFull    = 2'd1,
    StEmpty   = 2'd2,
    StInvalid = 2'd3
  } status_e;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
    logic clr;
  } smpq_cmd_t;

endpackage

// ===== rtl/core/smpq_cell.sv =====
// One slot of the sorted chain: holds a value and trades with its neighbors.
module smpq_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  smpq_pkg::smpq_cmd_t               cmd_i,
  input  logic [smpq_pkg::ValueW-1:0]       ins_value_i,
  input  logic                              above_ge_i,
  input  logic [smpq_pkg::ValueW-1:0]       above_value_i,
  input  logic [smpq_pkg::ValueW-1:0]       below_value_i,
  output logic                              ge_o,
  output logic [smpq_pkg::ValueW-1:0]       value_o
);

  logic [smpq_pkg::ValueW-1:0] value_q, value_d;

  // Keep our slot if it holds a value at least as large as the new one
  assign ge_o    = (value_q >= ins_value_i);
  assign value_o = value_q;

  // Pick the next slot content: clear, shift up on delete, shift down on insert
  always_comb begin
    value_d = value_q;
    priority if (cmd_i.clr) begin
      value_d = '0;
    end else if (cmd_i.del) begin
      value_d = below_value_i;
    end else if (cmd_i.ins && !ge_o) begin
      value_d = above_ge_i ? ins_value_i : above_value_i;
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

endmodule

// ===== rtl/core/sorted_max_priority_queue.sv =====
// Top level of the sorted max-priority queue built from a chain of slot cells.
//
//   channel   direction  handshake                   payload
//   request   in         in_valid_i / in_stall_o     opcode_i, value_i
//   result    out        out_valid_o / out_stall_i   status_o, removed_value_o, item_count_o
//
// On each request every cell compares the new value with its own and its upper
// neighbor's in parallel, then the whole chain shifts at once.
// One request can be taken per cycle; the result register holds one result and
// a request is stalled only while that result waits and the output is stalled.
// Reset clears every cell and the count at once; no sweep is needed.
module sorted_max_priority_queue #(
  parameter int unsigned CAPACITY = smpq_pkg::CapacityDef,
  localparam int unsigned CntW    = $clog2(CAPACITY + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [smpq_pkg::OpW-1:0]            opcode_i,
  input  logic [smpq_pkg::ValueW-1:0]         value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [smpq_pkg::StatusW-1:0]        status_o,
  output logic [smpq_pkg::ValueW-1:0]         removed_value_o,
  output logic [CntW-1:0]                     item_count_o
);

  logic                         accept;
  logic [CntW-1:0]              count_q, count_d;
  logic                         out_valid_q;
  smpq_pkg::status_e            status_q, status_d;
  logic [smpq_pkg::ValueW-1:0]  removed_q, removed_d;
  smpq_pkg::smpq_cmd_t          cmd;
  logic                         full, empty, value_ok;

  logic [smpq_pkg::ValueW-1:0]  vals [CAPACITY];
  logic                         ges  [CAPACITY];

  // Stall requests only while a result waits on a stalled output
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full     = (count_q == CntW'(CAPACITY));
  assign empty    = (count_q == '0);
  assign value_ok = (value_i >= smpq_pkg::ValueMin) && (value_i <= smpq_pkg::ValueMax);

  // Decode the request into a chain command, status and new count
  always_comb begin
    cmd       = '0;
    status_d  = smpq_pkg::StInvalid;
    removed_d = '0;
    count_d   = count_q;
    unique case (smpq_pkg::opcode_e'(opcode_i))
      smpq_pkg::OpInsert: begin
        priority if (full) begin
          status_d = smpq_pkg::StFull;
        end else if (!value_ok) begin
          status_d = smpq_pkg::StInvalid;
        end else begin
          status_d = smpq_pkg::StOk;
          cmd.ins  = accept;
          count_d  = count_q + CntW'(1);
        end
      end
      smpq_pkg::OpDelete: begin
        if (empty) begin
          status_d = smpq_pkg::StEmpty;
        end else begin
          status_d  = smpq_pkg::StOk;
          removed_d = vals[0];
          cmd.del   = accept;
          count_d   = count_q - CntW'(1);
        end
      end
      smpq_pkg::OpClear: begin
        status_d = smpq_pkg::StOk;
        cmd.clr  = accept;
        count_d  = '0;
      end
      default: begin
        status_d = smpq_pkg::StInvalid;
      end
    endcase
  end

  // Build the chain of slots, head at index zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                        above_ge;
    logic [smpq_pkg::ValueW-1:0] above_value;
    logic [smpq_pkg::ValueW-1:0] below_value;

    if (i == 0) begin : g_head
      assign above_ge    = 1'b1;
      assign above_value = '0;
    end else begin : g_mid
      assign above_ge    = ges[i-1];
      assign above_value = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign below_value = '0;
    end else begin : g_body
      assign below_value = vals[i+1];
    end

    smpq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .ins_value_i   (value_i),
      .above_ge_i    (above_ge),
      .above_value_i (above_value),
      .below_value_i (below_value),
      .ge_o          (ges[i]),
      .value_o       (vals[i])
    );
  end

  // Advance the count and the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result payload on each accepted request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign item_count_o    = count_q;

  // Count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("count exceeds capacity");

  // Head of the chain is never smaller than its neighbor
  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vals[0] >= vals[1])
    else $error("chain out of order at head");

  // An empty store holds nothing at the head
  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (vals[0] == '0))
    else $error("empty store with nonzero head");

  // A successful delete returns the old head
  a_delete_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd.del) |=> (removed_q == $past(vals[0])))
    else $error("delete returned wrong value");

endmodule
